>>> sv/rau_pkg.sv
// Package with shared constants, codes and the pipeline item type of the fraction ALU.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned SHIFT_W   = $clog2(DATA_W);
  localparam int unsigned GCD_STEPS = 2 * DATA_W;
  localparam int unsigned DIV_STEPS = DATA_W;

  localparam logic [KIND_W-1:0] KIND_SUM  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DIFF = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PROD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUOT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CMP  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RED  = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [DATA_W-1:0]  res_num;
    logic [DATA_W-1:0]  res_den;
    logic               less;
    logic               greater;
    logic               neg_n;
    logic               neg_d;
    logic               trivial;
    logic [DATA_W-1:0]  mag_n;
    logic [DATA_W-1:0]  mag_d;
    logic [DATA_W-1:0]  gx;
    logic [DATA_W-1:0]  gy;
    logic [SHIFT_W-1:0] gk;
    logic [DATA_W-1:0]  divisor;
    logic [DATA_W:0]    rem_n;
    logic [DATA_W:0]    rem_d;
  } item_t;

endpackage
`default_nettype wire

>>> sv/rau_if.sv
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface rau_in_if;
  import rau_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] a_num;
  logic signed [DATA_W-1:0] a_den;
  logic signed [DATA_W-1:0] b_num;
  logic signed [DATA_W-1:0] b_den;
  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] res_num;
  logic signed [DATA_W-1:0] res_den;
  logic                     less;
  logic                     greater;
  modport source (output valid, res_num, res_den, less, greater, input ready);
  modport sink (input valid, res_num, res_den, less, greater, output ready);
endinterface
`default_nettype wire

>>> sv/rau_arith.sv
// Two pipeline stages: cross products, then sums, compare and reduce setup.
`timescale 1ns / 1ps
`default_nettype none
module rau_arith import rau_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [KIND_W-1:0]        kind_i,
  input  wire logic signed [DATA_W-1:0] a_num_i,
  input  wire logic signed [DATA_W-1:0] a_den_i,
  input  wire logic signed [DATA_W-1:0] b_num_i,
  input  wire logic signed [DATA_W-1:0] b_den_i,
  output logic                          valid_o,
  output item_t                         item_o
);

  logic                       va_q;
  logic [KIND_W-1:0]          kind_q;
  logic signed [2*DATA_W-1:0] p_ab_q, p_ba_q, p_dd_q, p_nn_q;
  logic                       neg_n_q, neg_d_q, trivial_q;
  logic [DATA_W-1:0]          mag_n_q, mag_d_q;
  logic [DATA_W-1:0]          mag_n_d, mag_d_d;
  logic [2*DATA_W-1:0]        sum_w, diff_w;
  item_t                      item_d, item_q;
  logic                       vb_q;

  assign mag_n_d = a_num_i[DATA_W-1] ? (~a_num_i + 1'b1) : a_num_i;
  assign mag_d_d = a_den_i[DATA_W-1] ? (~a_den_i + 1'b1) : a_den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q    <= kind_i;
      p_ab_q    <= (2*DATA_W)'(a_num_i) * (2*DATA_W)'(b_den_i);
      p_ba_q    <= (2*DATA_W)'(b_num_i) * (2*DATA_W)'(a_den_i);
      p_dd_q    <= (2*DATA_W)'(a_den_i) * (2*DATA_W)'(b_den_i);
      p_nn_q    <= (2*DATA_W)'(a_num_i) * (2*DATA_W)'(b_num_i);
      neg_n_q   <= a_num_i[DATA_W-1];
      neg_d_q   <= a_den_i[DATA_W-1];
      trivial_q <= (a_num_i == '0) || (a_den_i == '0);
      mag_n_q   <= mag_n_d;
      mag_d_q   <= mag_d_d;
      item_q    <= item_d;
    end
  end

  assign sum_w  = p_ab_q + p_ba_q;
  assign diff_w = p_ab_q - p_ba_q;

  always_comb begin
    item_d         = '0;
    item_d.kind    = kind_q;
    item_d.neg_n   = neg_n_q;
    item_d.neg_d   = neg_d_q;
    item_d.trivial = trivial_q;
    item_d.mag_n   = mag_n_q;
    item_d.mag_d   = mag_d_q;
    item_d.gx      = mag_n_q;
    item_d.gy      = mag_d_q;
    case (kind_q)
      KIND_SUM: begin
        item_d.res_num = sum_w[DATA_W-1:0];
        item_d.res_den = p_dd_q[DATA_W-1:0];
      end
      KIND_DIFF: begin
        item_d.res_num = diff_w[DATA_W-1:0];
        item_d.res_den = p_dd_q[DATA_W-1:0];
      end
      KIND_PROD: begin
        item_d.res_num = p_nn_q[DATA_W-1:0];
        item_d.res_den = p_dd_q[DATA_W-1:0];
      end
      KIND_QUOT: begin
        item_d.res_num = p_ab_q[DATA_W-1:0];
        item_d.res_den = p_ba_q[DATA_W-1:0];
      end
      KIND_CMP: begin
        item_d.less    = p_ab_q < p_ba_q;
        item_d.greater = p_ab_q > p_ba_q;
      end
      default: ;
    endcase
  end

  assign valid_o = vb_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

>>> sv/rau_gcd_step.sv
// One registered step of the binary gcd on the reduce magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module rau_gcd_step import rau_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire item_t item_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_d, item_q;

  always_comb begin
    item_d = item_i;
    if (item_i.gx != '0 && item_i.gy != '0) begin
      case ({item_i.gx[0], item_i.gy[0]})
        2'b00: begin
          item_d.gx = item_i.gx >> 1;
          item_d.gy = item_i.gy >> 1;
          item_d.gk = item_i.gk + 1'b1;
        end
        2'b01: item_d.gx = item_i.gx >> 1;
        2'b10: item_d.gy = item_i.gy >> 1;
        default: begin
          if (item_i.gx >= item_i.gy) begin
            item_d.gx = (item_i.gx - item_i.gy) >> 1;
          end else begin
            item_d.gy = (item_i.gy - item_i.gx) >> 1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

>>> sv/rau_div_step.sv
// One registered restoring division step for both reduce magnitudes.
`timescale 1ns / 1ps
`default_nettype none
module rau_div_step import rau_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  valid_i,
  input  wire item_t item_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic              valid_q;
  item_t             item_d, item_q;
  logic [DATA_W:0]   trial_n, trial_d, dvs;

  assign dvs     = {1'b0, item_i.divisor};
  assign trial_n = {item_i.rem_n[DATA_W-1:0], item_i.mag_n[DATA_W-1]};
  assign trial_d = {item_i.rem_d[DATA_W-1:0], item_i.mag_d[DATA_W-1]};

  always_comb begin
    item_d = item_i;
    if (trial_n >= dvs) begin
      item_d.rem_n = trial_n - dvs;
      item_d.mag_n = {item_i.mag_n[DATA_W-2:0], 1'b1};
    end else begin
      item_d.rem_n = trial_n;
      item_d.mag_n = {item_i.mag_n[DATA_W-2:0], 1'b0};
    end
    if (trial_d >= dvs) begin
      item_d.rem_d = trial_d - dvs;
      item_d.mag_d = {item_i.mag_d[DATA_W-2:0], 1'b1};
    end else begin
      item_d.rem_d = trial_d;
      item_d.mag_d = {item_i.mag_d[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

>>> sv/rational_arithmetic_unit.sv
// Top level of the fraction ALU: arithmetic stages, gcd chain, divider chain and output.
// Every kind takes the same path: two arithmetic stages, 64 gcd steps,
// one divisor stage, 32 division steps and one output stage.
// Throughput is one beat per cycle; the whole pipeline holds while a result waits.
// The gcd step chain and the division step chain set the depth.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rau_in_if.sink    in_i,
  rau_out_if.source out_o
);

  logic  en;
  logic  gv [0:GCD_STEPS];
  item_t gq [0:GCD_STEPS];
  logic  dv [0:DIV_STEPS];
  item_t dq [0:DIV_STEPS];
  item_t fin_d;
  logic  dv0_q;
  item_t dq0_q;
  logic  out_valid_q;
  item_t out_q;
  logic [DATA_W-1:0] quo_n, quo_d;

  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  rau_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .kind_i  (in_i.kind),
    .a_num_i (in_i.a_num),
    .a_den_i (in_i.a_den),
    .b_num_i (in_i.b_num),
    .b_den_i (in_i.b_den),
    .valid_o (gv[0]),
    .item_o  (gq[0])
  );

  for (genvar i = 0; i < GCD_STEPS; i++) begin : g_gcd
    rau_gcd_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (gv[i]),
      .item_i  (gq[i]),
      .valid_o (gv[i+1]),
      .item_o  (gq[i+1])
    );
  end

  always_comb begin
    fin_d         = gq[GCD_STEPS];
    fin_d.divisor = gq[GCD_STEPS].trivial ? DATA_W'(1)
                  : ((gq[GCD_STEPS].gx | gq[GCD_STEPS].gy) << gq[GCD_STEPS].gk);
    fin_d.rem_n   = '0;
    fin_d.rem_d   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv0_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      dv0_q       <= gv[GCD_STEPS];
      out_valid_q <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dq0_q <= fin_d;
      out_q <= dq[DIV_STEPS];
    end
  end

  assign dv[0] = dv0_q;
  assign dq[0] = dq0_q;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    rau_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[j]),
      .item_i  (dq[j]),
      .valid_o (dv[j+1]),
      .item_o  (dq[j+1])
    );
  end

  assign quo_n = out_q.neg_n ? (~out_q.mag_n + 1'b1) : out_q.mag_n;
  assign quo_d = out_q.neg_d ? (~out_q.mag_d + 1'b1) : out_q.mag_d;

  assign out_o.valid   = out_valid_q;
  assign out_o.res_num = (out_q.kind == KIND_RED) ? quo_n : out_q.res_num;
  assign out_o.res_den = (out_q.kind == KIND_RED) ? quo_d : out_q.res_den;
  assign out_o.less    = out_q.less;
  assign out_o.greater = out_q.greater;

`ifndef ASSERT_OFF
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.less && out_o.greater))
    else $error("less and greater both set");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.less || out_o.greater)) |->
      (out_o.res_num == '0 && out_o.res_den == '0))
    else $error("compare beat carries nonzero fraction");

  a_gcd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gv[GCD_STEPS] |-> (gq[GCD_STEPS].gx == '0 || gq[GCD_STEPS].gy == '0))
    else $error("gcd chain did not converge");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_rational_arithmetic_unit.sv
// Testbench for the fraction ALU: directed and random beats checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        lt;
    logic        gt;
  } frac_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  rau_in_if  in_ch ();
  rau_out_if out_ch ();

  rational_arithmetic_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  frac_res_t  expected_q[$];
  int         mismatch_cnt = 0;
  int         fail_cnt = 0;
  longint     cycle_cnt = 0;
  bit         steady_mode = 1'b0;
  int         hold_cycles = 0;
  bit         ready_gaps = 1'b1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.kind    = '0;
    in_ch.a_num   = '0;
    in_ch.a_den   = '0;
    in_ch.b_num   = '0;
    in_ch.b_den   = '0;
    out_ch.ready  = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 2000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic frac_res_t predict_fraction(logic [2:0] kind, logic [31:0] an,
                                                  logic [31:0] ad, logic [31:0] bn,
                                                  logic [31:0] bd);
    frac_res_t r;
    longint sn, sd, tn, td, lhs, rhs, g, pn, pd;
    longint unsigned un, ud;
    sn = longint'($signed(an));
    sd = longint'($signed(ad));
    tn = longint'($signed(bn));
    td = longint'($signed(bd));
    r = '{32'd0, 32'd0, 1'b0, 1'b0};
    case (kind)
      KIND_SUM: begin
        pn = sn * td + tn * sd;
        pd = sd * td;
        r.num = pn[31:0];
        r.den = pd[31:0];
      end
      KIND_DIFF: begin
        pn = sn * td - tn * sd;
        pd = sd * td;
        r.num = pn[31:0];
        r.den = pd[31:0];
      end
      KIND_PROD: begin
        pn = sn * tn;
        pd = sd * td;
        r.num = pn[31:0];
        r.den = pd[31:0];
      end
      KIND_QUOT: begin
        pn = sn * td;
        pd = tn * sd;
        r.num = pn[31:0];
        r.den = pd[31:0];
      end
      KIND_CMP: begin
        lhs = sn * td;
        rhs = tn * sd;
        r.lt = lhs < rhs;
        r.gt = lhs > rhs;
      end
      KIND_RED: begin
        un = (sn < 0) ? -sn : sn;
        ud = (sd < 0) ? -sd : sd;
        g = 1;
        if (un != 0 && ud != 0) g = longint'(gcd64(un, ud));
        pn = sn / g;
        pd = sd / g;
        r.num = pn[31:0];
        r.den = pd[31:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: random ready, with a long hold-off when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= (steady_mode || !ready_gaps) ? 1'b1 : ($urandom_range(99) >= 27);
    end
  end

  always @(posedge clk_i) begin
    frac_res_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        fail_cnt++;
        $display("Unexpected result beat num=%h den=%h", out_ch.res_num, out_ch.res_den);
      end else begin
        e = expected_q.pop_front();
        if (e.num !== out_ch.res_num || e.den !== out_ch.res_den ||
            e.lt !== out_ch.less || e.gt !== out_ch.greater) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Mismatch: expected num=%h den=%h lt=%b gt=%b, got num=%h den=%h lt=%b gt=%b",
                     e.num, e.den, e.lt, e.gt, out_ch.res_num, out_ch.res_den,
                     out_ch.less, out_ch.greater);
        end
      end
    end
  end

  task automatic send_fraction(logic [2:0] kind, logic [31:0] an, logic [31:0] ad,
                               logic [31:0] bn, logic [31:0] bd, bit gaps);
    while (gaps && !steady_mode && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.a_num <= an;
    in_ch.a_den <= ad;
    in_ch.b_num <= bn;
    in_ch.b_den <= bd;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_q.push_back(predict_fraction(kind, an, ad, bn, bd));
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom_range(20) - 10;
      1: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'h0};
      2: return 32'h7fffffff - $urandom_range(3);
      3: return $urandom_range(1000) * (1 << $urandom_range(12));
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] ext[4];
    logic [2:0] k;
    ext = '{32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h0};
    for (int i = 0; i < 4; i++) begin
      k = i[2:0];
      send_fraction(k, ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4], 1'b0);
    end
    send_fraction(KIND_CMP, 32'd1, 32'd2, 32'd1, 32'd3, 1'b0);
    send_fraction(KIND_CMP, 32'd1, -32'sd2, 32'd1, 32'd3, 1'b0);
    send_fraction(KIND_CMP, 32'd2, 32'd4, 32'd1, 32'd2, 1'b0);
    send_fraction(KIND_CMP, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0);
    send_fraction(KIND_RED, 32'd12, 32'd18, 32'd0, 32'd0, 1'b0);
    send_fraction(KIND_RED, -32'sd12, 32'd18, 32'd0, 32'd0, 1'b0);
    send_fraction(KIND_RED, 32'd12, -32'sd18, 32'd5, 32'd5, 1'b0);
    send_fraction(KIND_RED, 32'd0, 32'd7, 32'd0, 32'd0, 1'b0);
    send_fraction(KIND_RED, 32'd9, 32'd0, 32'd0, 32'd0, 1'b0);
    send_fraction(KIND_RED, 32'h80000000, 32'h80000000, 32'd0, 32'd0, 1'b0);
    send_fraction(KIND_RED, 32'h80000000, 32'd6, 32'd0, 32'd0, 1'b0);
    send_fraction(KIND_RED, 32'h7fffffff, 32'hffffffff, 32'd0, 32'd0, 1'b0);
    send_fraction(KIND_SUM, 32'd1, 32'd0, 32'd1, 32'd0, 1'b0);
    send_fraction(KIND_QUOT, 32'd3, 32'd4, 32'd0, 32'd5, 1'b0);
    send_fraction(3'd6, 32'd1, 32'd2, 32'd3, 32'd4, 1'b0);
    send_fraction(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0);
  endtask

  task automatic test_random(int count, bit gaps);
    for (int i = 0; i < count; i++)
      send_fraction(3'($urandom_range(7)), rand_word(), rand_word(), rand_word(),
                    rand_word(), gaps);
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    test_random(150, 1'b0);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained();
    test_random(300, 1'b1);
    steady_mode = 1'b1;
    test_random(150, 1'b1);
    steady_mode = 1'b0;
    test_backpressure();
    test_random(150, 1'b1);
    wait_drained();
    repeat (120) @(posedge clk_i);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
